>>> rtl/gcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcf_pkg
// Shared types, sizes and helpers for the graph canonical form search block.
// ----------------------------------------------------------------------------
package gcf_pkg;

  localparam int MAX_VERTICES         = 10;
  localparam int MAX_SEARCH_NODES_DEF = 54;
  localparam int NSLOT                = MAX_VERTICES + 2;
  localparam int PW                   = $clog2(NSLOT);
  localparam int NUM_W                = 45;
  localparam int ROW_W                = MAX_VERTICES - 1;
  localparam int PAIR_W               = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);

  typedef logic [PW-1:0] pos_t;

  // One search tree node as it sits in the node store.
  typedef struct packed {
    logic                    surv;
    logic [NUM_W-1:0]        numv;
    logic [ROW_W-1:0]        rowv;
    pos_t                    cells;
    pos_t [NSLOT-1:0]        bnd;
    pos_t [MAX_VERTICES-1:0] perm;
  } node_t;

  typedef logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj_t;

  typedef struct packed {
    logic start;
    pos_t lv;
    pos_t nv;
    pos_t src;
  } build_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADJ, S_ROOT, S_LV, S_RD, S_LOAD, S_DEG, S_NODE, S_ADV, S_PICK,
    S_BUILD, S_DX_RD, S_DX_LD, S_DY_RD, S_DY_LD, S_MARK, S_DX_NEXT, S_LVEND, S_OUT
  } srch_state_t;

  typedef enum logic [2:0] {
    R_IDLE, R_CELL, R_SCAN, R_CEND, R_NUM, R_DONE
  } bld_state_t;

  function automatic pos_t clamp_pos(int v, int lo, int hi);
    int r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return pos_t'(r);
  endfunction

endpackage

>>> rtl/gcf_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcf_node_mem
// Node store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gcf_node_mem #(
  parameter int DEPTH = 2 * gcf_pkg::MAX_SEARCH_NODES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  gcf_pkg::node_t           wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output gcf_pkg::node_t           rdata
);
  import gcf_pkg::*;

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gcf_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcf_build
// Child builder: pins a vertex, splits the later cells one element per cycle
// and forms the permuted number and the fixed-vertex row one row per cycle.
// ----------------------------------------------------------------------------
module gcf_build (
  input  logic                clk,
  input  logic                rst_n,
  input  gcf_pkg::build_req_t req,
  input  gcf_pkg::node_t      base,
  input  gcf_pkg::adj_t       adj,
  output logic                done,
  output gcf_pkg::node_t      child
);
  import gcf_pkg::*;

  bld_state_t state_r, state_nxt;
  node_t ch_r, pinned;
  pos_t [MAX_VERTICES-1:0] nperm_r;
  pos_t [NSLOT-1:0] nb_r, nb_nxt;
  pos_t cnt_r, cnt_nxt, cx_r, sy_r, clo_r, chi_r, wp_r, ones_r, rx_r, lv_r, nv_r;
  logic spass_r;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [ROW_W-1:0] rb;
  pos_t fv, elem, cell_lo, cell_hi, row_v;
  logic cell_big, adj_bit, take, cells_done;

  function automatic node_t pin_fn(node_t t, pos_t lv, pos_t src);
    node_t r;
    pos_t  vert;
    int    strt;
    r      = t;
    r.surv = 1'b0;
    vert   = t.perm[src];
    for (int p = 1; p < MAX_VERTICES; p++) begin
      if (p > int'(lv) - 1 && p <= int'(src)) r.perm[p] = t.perm[p-1];
    end
    r.perm[pos_t'(lv - 1'b1)] = vert;
    strt = (lv > 1) ? int'(t.bnd[pos_t'(lv - 1'b1)]) + 1 : 0;
    if (int'(t.bnd[lv]) - strt + 1 > 1 && int'(t.cells) + 1 < NSLOT) begin
      for (int x = 1; x < NSLOT; x++) begin
        if (x > int'(lv) && x <= int'(t.cells) + 1) r.bnd[x] = t.bnd[x-1];
      end
      r.bnd[lv] = pos_t'(lv - 1'b1);
      r.cells   = pos_t'(t.cells + 1'b1);
    end
    return r;
  endfunction

  assign pinned     = pin_fn(base, req.lv, req.src);
  assign fv         = ch_r.perm[pos_t'(lv_r - 1'b1)];
  assign cells_done = cx_r >= ch_r.cells;
  assign cell_lo    = clamp_pos(int'(ch_r.bnd[cx_r]) + 1, 0, int'(nv_r) - 1);
  assign cell_hi    = clamp_pos(int'(ch_r.bnd[pos_t'(cx_r + 1'b1)]), 0, int'(nv_r) - 1);
  assign cell_big   = cell_hi > cell_lo;
  assign elem       = ch_r.perm[sy_r];
  assign adj_bit    = adj[fv][elem];
  assign take       = spass_r ? !adj_bit : adj_bit;
  assign row_v      = ch_r.perm[rx_r];

  // Boundaries appended after a cell: the split point, then the cell end.
  always_comb begin
    int c;
    nb_nxt = nb_r;
    c      = int'(cnt_r);
    if (state_r == R_CEND && ones_r != '0 &&
        int'(ones_r) < int'(chi_r) - int'(clo_r) + 1 && c + 1 < NSLOT) begin
      nb_nxt[pos_t'(c + 1)] = pos_t'(clo_r + ones_r - 1'b1);
      c++;
    end
    if ((state_r == R_CEND || (state_r == R_CELL && !cells_done && !cell_big)) &&
        c + 1 < NSLOT) begin
      nb_nxt[pos_t'(c + 1)] = ch_r.bnd[pos_t'(cx_r + 1'b1)];
      c++;
    end
    cnt_nxt = pos_t'(c);
  end

  always_comb begin
    rb = '0;
    for (int y = 0; y < MAX_VERTICES; y++) begin
      if (y > int'(rx_r) && y < int'(nv_r)) rb = {rb[ROW_W-2:0], adj[row_v][ch_r.perm[y]]};
    end
    acc_nxt = (acc_r << (nv_r - 1'b1 - rx_r)) | NUM_W'(rb);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      R_IDLE: if (req.start) state_nxt = R_CELL;
      R_CELL: begin
        if (cells_done) state_nxt = R_NUM;
        else if (cell_big) state_nxt = R_SCAN;
      end
      R_SCAN: if (sy_r == chi_r && spass_r) state_nxt = R_CEND;
      R_CEND: state_nxt = R_CELL;
      R_NUM:  if (rx_r == pos_t'(nv_r - 2'd2)) state_nxt = R_DONE;
      R_DONE: state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_comb begin
    done  = (state_r == R_DONE);
    child = ch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        if (req.start) begin
          ch_r      <= pinned;
          lv_r      <= req.lv;
          nv_r      <= req.nv;
          cx_r      <= req.lv;
          cnt_r     <= req.lv;
          nb_r      <= pinned.bnd;
          nperm_r   <= pinned.perm;
        end
      end
      R_CELL: begin
        if (cells_done) begin
          ch_r.perm  <= nperm_r;
          ch_r.bnd   <= nb_r;
          ch_r.cells <= cnt_r;
          rx_r       <= '0;
          acc_r      <= '0;
        end else if (cell_big) begin
          sy_r    <= cell_lo;
          clo_r   <= cell_lo;
          chi_r   <= cell_hi;
          wp_r    <= cell_lo;
          ones_r  <= '0;
          spass_r <= 1'b0;
        end else begin
          nb_r  <= nb_nxt;
          cnt_r <= cnt_nxt;
          cx_r  <= pos_t'(cx_r + 1'b1);
        end
      end
      R_SCAN: begin
        if (take) begin
          nperm_r[wp_r] <= elem;
          wp_r          <= pos_t'(wp_r + 1'b1);
        end
        if (!spass_r && adj_bit) ones_r <= pos_t'(ones_r + 1'b1);
        if (sy_r == chi_r) begin
          if (!spass_r) begin
            spass_r <= 1'b1;
            sy_r    <= clo_r;
          end
        end else begin
          sy_r <= pos_t'(sy_r + 1'b1);
        end
      end
      R_CEND: begin
        nb_r  <= nb_nxt;
        cnt_r <= cnt_nxt;
        cx_r  <= pos_t'(cx_r + 1'b1);
      end
      R_NUM: begin
        acc_r <= acc_nxt;
        rx_r  <= pos_t'(rx_r + 1'b1);
        if (rx_r == pos_t'(lv_r - 1'b1)) ch_r.rowv <= rb;
        if (rx_r == pos_t'(nv_r - 2'd2)) ch_r.numv <= acc_nxt;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/graph_canonical_form_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_canonical_form_search
// Operation: the adjacency is loaded first; per level, two passes run over the survivors,
// one child is built per picked vertex and candidates are read back pairwise from the
// node store for duplicate removal. All of these reads share its single read port.
// Throughput: one graph at a time; busy is high from start until the result beat.
// Reset: synchronous active-low rst_n returns the controller to idle; the store is not
// cleared. The result beat lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module graph_canonical_form_search #(
  parameter int MAX_SEARCH_NODES = gcf_pkg::MAX_SEARCH_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_vertex_count,
  input  logic [44:0] in_adjacency_bits,
  output logic        out_valid,
  output logic [44:0] out_canonical_number,
  output logic        out_tree_overflow
);
  import gcf_pkg::*;

  localparam int IW    = $clog2(MAX_SEARCH_NODES);
  localparam int DEPTH = 2 * MAX_SEARCH_NODES;
  localparam int AW    = $clog2(DEPTH);

  srch_state_t state_r, state_nxt;
  pos_t nv_r, nv_in, ax_r, ay_r, lv_r, lo, hi_r, y_r, top_r, topall_r, deg;
  logic [NUM_W-1:0] bits_r, best_r, num_out_r;
  logic [PAIR_W-1:0] pos_r, pairs_in;
  adj_t adj_r;
  logic bank_r, pass2_r, first_r, act_r, allfixed_r, ovf_out_r, adj_b;
  logic [IW-1:0] nold_r, nchild_r, idx_r, dx_r, dy_r;
  pos_t [MAX_VERTICES-1:0] dg_r;
  logic [ROW_W-1:0] rmax_r;
  node_t node_r, cur_r, root, mem_wdata, mem_rdata, child;
  logic mem_we, bld_done, pick_here, ovf_hit;
  logic [AW-1:0] mem_waddr, mem_raddr;
  build_req_t req;

  function automatic logic [AW-1:0] addr_of(logic b, logic [IW-1:0] i);
    return b ? AW'(i) + AW'(MAX_SEARCH_NODES) : AW'(i);
  endfunction

  gcf_node_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gcf_build u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .base  (node_r),
    .adj   (adj_r),
    .done  (bld_done),
    .child (child)
  );

  assign nv_in    = (in_vertex_count > 4'(MAX_VERTICES)) ? pos_t'(MAX_VERTICES)
                                                         : pos_t'(in_vertex_count);
  assign pairs_in = PAIR_W'((8'(nv_in) * 8'(nv_in - 1'b1)) >> 1);
  assign adj_b    = (pos_r < PAIR_W'(NUM_W)) ? bits_r[pos_r] : 1'b0;
  assign lo       = pos_t'(lv_r - 1'b1);
  assign pick_here = (y_r <= hi_r) && (dg_r[y_r] == top_r);
  assign ovf_hit  = (({1'b0, nchild_r} + 1'b1) >= (IW+1)'(MAX_SEARCH_NODES));

  always_comb begin
    root       = '0;
    root.surv  = 1'b1;
    root.cells = pos_t'(1);
    root.bnd[1] = pos_t'(nv_r - 1'b1);
    for (int x = 0; x < MAX_VERTICES; x++) begin
      if (x < int'(nv_r)) root.perm[x] = pos_t'(x);
    end
  end

  // In-cell degree of the vertex at position y.
  always_comb begin
    deg = '0;
    for (int z = 0; z < MAX_VERTICES; z++) begin
      if (pos_t'(z) >= lo && pos_t'(z) <= hi_r) begin
        deg = pos_t'(deg + adj_r[node_r.perm[y_r]][node_r.perm[z]]);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (nv_in < pos_t'(2)) ? S_OUT : S_ADJ;
      end
      S_ADJ: begin
        if (ay_r == pos_t'(nv_r - 1'b1) && ax_r == pos_t'(nv_r - 2'd2)) state_nxt = S_ROOT;
      end
      S_ROOT: state_nxt = S_LV;
      S_LV:   state_nxt = S_RD;
      S_RD:   state_nxt = S_LOAD;
      S_LOAD: state_nxt = mem_rdata.surv ? S_DEG : S_NODE;
      S_DEG:  if (y_r == hi_r) state_nxt = S_NODE;
      S_NODE: state_nxt = (pass2_r && act_r && top_r == topall_r) ? S_PICK : S_ADV;
      S_ADV: begin
        if (idx_r + 1'b1 == nold_r) state_nxt = pass2_r ? S_DX_RD : S_RD;
        else state_nxt = S_RD;
      end
      S_PICK: begin
        if (y_r > hi_r) state_nxt = S_ADV;
        else if (pick_here) state_nxt = ovf_hit ? S_OUT : S_BUILD;
      end
      S_BUILD: if (bld_done) state_nxt = S_PICK;
      S_DX_RD: state_nxt = S_DX_LD;
      S_DX_LD: begin
        if (mem_rdata.rowv != rmax_r) state_nxt = S_DX_NEXT;
        else if (dx_r == '0) state_nxt = S_MARK;
        else state_nxt = S_DY_RD;
      end
      S_DY_RD: state_nxt = S_DY_LD;
      S_DY_LD: begin
        if (mem_rdata.surv && mem_rdata.numv == cur_r.numv) state_nxt = S_DX_NEXT;
        else if (dy_r + 1'b1 == dx_r) state_nxt = S_MARK;
        else state_nxt = S_DY_RD;
      end
      S_MARK:    state_nxt = S_DX_NEXT;
      S_DX_NEXT: state_nxt = (dx_r + 1'b1 == nchild_r) ? S_LVEND : S_DX_RD;
      S_LVEND: begin
        state_nxt = (allfixed_r || lv_r == pos_t'(nv_r - 1'b1)) ? S_OUT : S_LV;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    out_canonical_number = num_out_r;
    out_tree_overflow    = ovf_out_r;
    req.start = (state_r == S_PICK) && (y_r <= hi_r) && pick_here && !ovf_hit;
    req.lv    = lv_r;
    req.nv    = nv_r;
    req.src   = y_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = root;
    mem_raddr = '0;
    case (state_r)
      S_ROOT: mem_we = 1'b1;
      S_BUILD: begin
        mem_we    = bld_done;
        mem_waddr = addr_of(~bank_r, nchild_r);
        mem_wdata = child;
      end
      S_MARK: begin
        mem_we         = 1'b1;
        mem_waddr      = addr_of(~bank_r, dx_r);
        mem_wdata      = cur_r;
        mem_wdata.surv = 1'b1;
      end
      S_RD:    mem_raddr = addr_of(bank_r, idx_r);
      S_DX_RD: mem_raddr = addr_of(~bank_r, dx_r);
      S_DY_RD: mem_raddr = addr_of(~bank_r, dy_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          nv_r      <= nv_in;
          bits_r    <= in_adjacency_bits;
          adj_r     <= '0;
          ax_r      <= '0;
          ay_r      <= pos_t'(1);
          pos_r     <= PAIR_W'(pairs_in - 1'b1);
          num_out_r <= '0;
          ovf_out_r <= 1'b0;
        end
      end
      S_ADJ: begin
        adj_r[ax_r][ay_r] <= adj_b;
        adj_r[ay_r][ax_r] <= adj_b;
        pos_r <= PAIR_W'(pos_r - 1'b1);
        if (ay_r == pos_t'(nv_r - 1'b1)) begin
          ax_r <= pos_t'(ax_r + 1'b1);
          ay_r <= pos_t'(ax_r + 2'd2);
        end else begin
          ay_r <= pos_t'(ay_r + 1'b1);
        end
      end
      S_ROOT: begin
        bank_r <= 1'b0;
        nold_r <= IW'(1);
        lv_r   <= pos_t'(1);
      end
      S_LV: begin
        idx_r    <= '0;
        pass2_r  <= 1'b0;
        first_r  <= 1'b1;
        topall_r <= '0;
        nchild_r <= '0;
        rmax_r   <= '0;
      end
      S_LOAD: begin
        node_r <= mem_rdata;
        act_r  <= mem_rdata.surv;
        top_r  <= '0;
        y_r    <= lo;
        if (mem_rdata.surv && first_r) begin
          // The open cell's upper bound comes from the first surviving node.
          hi_r    <= clamp_pos(int'(mem_rdata.bnd[lv_r]), int'(lo), int'(nv_r) - 1);
          first_r <= 1'b0;
        end
      end
      S_DEG: begin
        dg_r[y_r] <= deg;
        if (deg > top_r) top_r <= deg;
        y_r <= pos_t'(y_r + 1'b1);
      end
      S_NODE: begin
        y_r <= lo;
        if (!pass2_r && act_r && top_r > topall_r) topall_r <= top_r;
      end
      S_ADV: begin
        if (idx_r + 1'b1 == nold_r) begin
          idx_r      <= '0;
          pass2_r    <= 1'b1;
          dx_r       <= '0;
          best_r     <= '0;
          allfixed_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_PICK: begin
        if (y_r <= hi_r) begin
          if (pick_here && ovf_hit) begin
            num_out_r <= '0;
            ovf_out_r <= 1'b1;
          end else if (!pick_here) begin
            y_r <= pos_t'(y_r + 1'b1);
          end
        end
      end
      S_BUILD: begin
        if (bld_done) begin
          nchild_r <= nchild_r + 1'b1;
          y_r      <= pos_t'(y_r + 1'b1);
          if (child.rowv > rmax_r) rmax_r <= child.rowv;
        end
      end
      S_DX_LD: begin
        cur_r <= mem_rdata;
        dy_r  <= '0;
      end
      S_DY_LD: dy_r <= dy_r + 1'b1;
      S_MARK: begin
        if (cur_r.numv > best_r) best_r <= cur_r.numv;
        if (cur_r.cells < nv_r) allfixed_r <= 1'b0;
      end
      S_DX_NEXT: dx_r <= dx_r + 1'b1;
      S_LVEND: begin
        if (allfixed_r || lv_r == pos_t'(nv_r - 1'b1)) begin
          num_out_r <= best_r;
          ovf_out_r <= 1'b0;
        end else begin
          lv_r   <= pos_t'(lv_r + 1'b1);
          nold_r <= nchild_r;
          bank_r <= ~bank_r;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> dv/graph_canonical_form_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_canonical_form_search_tb
// Self-checking bench for the canonical labeling search. A behavioral model
// of the pruned search predicts the canonical number and the overflow flag
// for every graph that the block accepts. Each result beat is compared with
// the oldest prediction. Directed graphs cover the edge cases. Random graphs,
// mostly on few vertices, follow with random start gaps, then a run without gaps.
// ----------------------------------------------------------------------------
module graph_canonical_form_search_tb;
  import gcf_pkg::*;

  localparam int NODES      = MAX_SEARCH_NODES_DEF;
  localparam int SLOTS      = NSLOT;
  localparam int CYCLE_CAP  = 100_000_000;
  localparam int DRAIN_WAIT = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_vertex_count = '0;
  logic [44:0] in_adjacency_bits = '0;
  logic        out_valid;
  logic [44:0] out_canonical_number;
  logic        out_tree_overflow;

  graph_canonical_form_search uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex_count(in_vertex_count), .in_adjacency_bits(in_adjacency_bits),
    .out_valid(out_valid), .out_canonical_number(out_canonical_number),
    .out_tree_overflow(out_tree_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [44:0] canon;
    logic        ovf;
  } canon_result_t;

  canon_result_t expected_canon_q[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  gaps_enabled = 1'b1;

  // Model state of the labeling search.
  bit [63:0] edge_row [SLOTS];
  int  old_cells [NODES];
  int  old_perm  [NODES][SLOTS];
  int  old_bnd   [NODES][SLOTS];
  int  nw_cells  [NODES];
  int  nw_perm   [NODES][SLOTS];
  int  nw_bnd    [NODES][SLOTS];
  logic [63:0] child_num [NODES];
  int  child_row [NODES];
  int  survivor  [NODES];
  int  top_deg   [NODES];
  int  pick_cnt  [NODES];
  int  pick_pos  [NODES][SLOTS];
  int  cand_idx  [NODES];

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit linked(int a, int b);
    return edge_row[a][b];
  endfunction

  task automatic fix_vertex(int c, int lv, int src);
    int x;
    int first;
    int vert;
    vert = nw_perm[c][src];
    for (x = src; x > lv - 1; x--) nw_perm[c][x] = nw_perm[c][x-1];
    nw_perm[c][lv-1] = vert;
    first = (lv > 1) ? nw_bnd[c][lv-1] + 1 : 0;
    if (nw_bnd[c][lv] - first + 1 > 1 && nw_cells[c] + 1 < SLOTS) begin
      for (x = nw_cells[c] + 1; x > lv; x--) nw_bnd[c][x] = nw_bnd[c][x-1];
      nw_bnd[c][lv] = lv - 1;
      nw_cells[c]++;
    end
  endtask

  task automatic refine_cells(int c, int lv, int nv);
    int nb [SLOTS];
    int buffer [SLOTS];
    int cnt, x, y, w, fv, lo, hi, ones;
    fv = nw_perm[c][lv-1];
    for (x = 1; x <= lv; x++) nb[x] = nw_bnd[c][x];
    cnt = lv;
    for (x = lv; x < nw_cells[c]; x++) begin
      lo = clip(nw_bnd[c][x] + 1, 0, nv - 1);
      hi = clip(nw_bnd[c][x+1], 0, nv - 1);
      ones = 0;
      if (hi - lo + 1 > 1) begin
        w = 0;
        for (y = lo; y <= hi; y++)
          if (linked(fv, nw_perm[c][y])) begin
            buffer[w] = nw_perm[c][y];
            w++;
          end
        ones = w;
        for (y = lo; y <= hi; y++)
          if (!linked(fv, nw_perm[c][y])) begin
            buffer[w] = nw_perm[c][y];
            w++;
          end
        for (y = 0; y < w; y++) nw_perm[c][lo + y] = buffer[y];
        if (ones > 0 && ones < hi - lo + 1 && cnt + 1 < SLOTS) begin
          cnt++;
          nb[cnt] = lo + ones - 1;
        end
      end
      if (cnt + 1 < SLOTS) begin
        cnt++;
        nb[cnt] = nw_bnd[c][x+1];
      end
    end
    for (x = 1; x <= cnt; x++) nw_bnd[c][x] = nb[x];
    nw_cells[c] = cnt;
  endtask

  task automatic score_child(int c, int lv, int nv);
    logic [63:0] acc;
    int row, x, y, fv;
    acc = '0;
    for (x = 0; x < nv - 1; x++)
      for (y = x + 1; y < nv; y++)
        acc = {acc[62:0], linked(nw_perm[c][x], nw_perm[c][y])};
    child_num[c] = acc;
    row = 0;
    fv = nw_perm[c][lv-1];
    for (y = lv; y < nv; y++) row = (row << 1) | int'(linked(fv, nw_perm[c][y]));
    child_row[c] = row;
  endtask

  task automatic predict_canon(input logic [3:0] vcount, input logic [44:0] bits,
                               output canon_result_t res);
    int nv, pairs, idx, x, y, z, k, lv, nsurv, nold, lo, hi, topall, nchild, ncand;
    int rmax, top;
    int dg [SLOTS];
    bit allfixed, dup;
    logic [63:0] best;
    res = '0;
    nv = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
    if (nv < 2) return;
    for (x = 0; x < SLOTS; x++) edge_row[x] = '0;
    pairs = nv * (nv - 1) / 2;
    idx = 0;
    for (x = 0; x < nv - 1; x++)
      for (y = x + 1; y < nv; y++) begin
        edge_row[x][y] = bits[pairs - 1 - idx];
        edge_row[y][x] = bits[pairs - 1 - idx];
        idx++;
      end
    for (x = 0; x < SLOTS; x++) begin
      nw_perm[0][x] = (x < nv) ? x : 0;
      nw_bnd[0][x] = 0;
    end
    nw_cells[0] = 1;
    nw_bnd[0][1] = nv - 1;
    survivor[0] = 0;
    nsurv = 1;
    for (lv = 1; lv < nv; lv++) begin
      nold = nsurv;
      lo = lv - 1;
      topall = -1;
      nchild = 0;
      ncand = 0;
      rmax = 0;
      allfixed = 1'b1;
      for (x = 0; x < nold; x++) begin
        old_cells[x] = nw_cells[survivor[x]];
        old_perm[x] = nw_perm[survivor[x]];
        old_bnd[x] = nw_bnd[survivor[x]];
      end
      hi = clip(old_bnd[0][lv], lo, nv - 1);
      for (x = 0; x < nold; x++) begin
        top = -1;
        for (y = lo; y <= hi; y++) begin
          dg[y] = 0;
          for (z = lo; z <= hi; z++) dg[y] += int'(linked(old_perm[x][y], old_perm[x][z]));
          if (dg[y] > top) top = dg[y];
        end
        pick_cnt[x] = 0;
        for (y = lo; y <= hi; y++)
          if (dg[y] == top) begin
            pick_pos[x][pick_cnt[x]] = y;
            pick_cnt[x]++;
          end
        top_deg[x] = top;
        if (top > topall) topall = top;
      end
      for (x = 0; x < nold; x++) begin
        if (top_deg[x] != topall) continue;
        for (y = 0; y < pick_cnt[x]; y++) begin
          if (nchild + 1 >= NODES) begin
            res.ovf = 1'b1;
            return;
          end
          nw_cells[nchild] = old_cells[x];
          nw_perm[nchild] = old_perm[x];
          nw_bnd[nchild] = old_bnd[x];
          fix_vertex(nchild, lv, pick_pos[x][y]);
          refine_cells(nchild, lv, nv);
          score_child(nchild, lv, nv);
          nchild++;
        end
      end
      for (x = 0; x < nchild; x++) if (child_row[x] > rmax) rmax = child_row[x];
      for (x = 0; x < nchild; x++)
        if (child_row[x] == rmax) begin
          cand_idx[ncand] = x;
          ncand++;
        end
      nsurv = 0;
      for (x = 0; x < ncand; x++) begin
        dup = 1'b0;
        for (k = 0; k < x; k++) if (child_num[cand_idx[k]] == child_num[cand_idx[x]]) dup = 1'b1;
        if (!dup) begin
          survivor[nsurv] = cand_idx[x];
          nsurv++;
        end
      end
      for (x = 0; x < nsurv; x++) if (nw_cells[survivor[x]] < nv) allfixed = 1'b0;
      if (allfixed) break;
    end
    best = '0;
    for (x = 0; x < nsurv; x++) if (child_num[survivor[x]] > best) best = child_num[survivor[x]];
    res.canon = best[44:0];
  endtask

  // Sends one graph; the prediction is queued on the falling edge ahead of the
  // accepting rising edge, so it is always in place before the result beat.
  task automatic send_graph(input logic [3:0] vcount, input logic [44:0] bits);
    canon_result_t res;
    int gap;
    @(negedge clk);
    if (gaps_enabled && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    while (busy) @(negedge clk);
    in_vertex_count = vcount;
    in_adjacency_bits = bits;
    start = 1'b1;
    predict_canon(vcount, bits, res);
    expected_canon_q.push_back(res);
    @(negedge clk);
    start = 1'b0;
    in_vertex_count = 4'($urandom);
    in_adjacency_bits = 45'({$urandom, $urandom});
  endtask

  function automatic logic [44:0] random_edges();
    logic [44:0] a, b;
    a = 45'({$urandom, $urandom});
    b = 45'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return a & b;
      1: return a | b;
      default: return a;
    endcase
  endfunction

  task automatic test_edge_cases();
    send_graph(4'd0, '1);
    send_graph(4'd1, '1);
    send_graph(4'd2, '0);
    send_graph(4'd2, 45'd1);
    send_graph(4'd3, 45'b110);
    send_graph(4'd4, 45'b101101);
    send_graph(4'd5, 45'h2aa);
    send_graph(4'd6, 45'h5a5a);
    send_graph(4'd7, 45'h0f0f0);
    send_graph(4'd8, '1);
    send_graph(4'd10, '0);
    send_graph(4'd10, '1);
    send_graph(4'd10, 45'h1 << 44);
    send_graph(4'd10, 45'h15555_5555_555);
    send_graph(4'd10, 45'h0aaaa_aaaa_aaa);
    send_graph(4'd11, 45'h12345_6789_abc);
    send_graph(4'd15, 45'h1ffff_0000_fff);
    send_graph(4'd3, '1);
    send_graph(4'd9, 45'h00000_0000_fff);
    // A path on six vertices keeps many equivalent branches alive.
    send_graph(4'd6, 45'b100011000010010);
  endtask

  task automatic test_random_graphs(int count);
    logic [3:0] vc;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) vc = 4'($urandom_range(2, 7));
      else vc = 4'($urandom_range(0, 15));
      send_graph(vc, random_edges());
    end
  endtask

  task automatic test_back_to_back(int count);
    gaps_enabled = 1'b0;
    for (int i = 0; i < count; i++)
      send_graph(4'($urandom_range(2, 8)), random_edges());
  endtask

  always @(posedge clk) begin
    canon_result_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_canon_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result beat: canon=%h ovf=%b",
                   out_canonical_number, out_tree_overflow);
      end else begin
        exp_res = expected_canon_q.pop_front();
        if (exp_res.canon !== out_canonical_number || exp_res.ovf !== out_tree_overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected canon=%h ovf=%b, actual canon=%h ovf=%b",
                     exp_res.canon, exp_res.ovf, out_canonical_number, out_tree_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_edge_cases();
    test_random_graphs(250);
    test_back_to_back(30);
    while (expected_canon_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_canon_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
